FILE: sv/bffa_pkg.sv
// Shared types and constants for the bitmap first-free allocator.
`default_nettype none

package bffa_pkg;

  localparam int ADDR_NUM_W  = 32;
  localparam int COUNT_IN_W  = 5;
  localparam int STATUS_W    = 2;
  localparam int FREE_LEFT_W = 11;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

  localparam logic [ADDR_NUM_W-1:0] BASE_RESET = 32'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REPORT,
    ST_LOAD,
    ST_SCAN,
    ST_FLOAD
  } state_t;

endpackage

`default_nettype wire

FILE: sv/bffa_ram.sv
// Bitmap word memory: one write port, one registered read port.
`default_nettype none

module bffa_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/bffa_ffz.sv
// Find-first-zero unit: lowest clear bit of one bitmap word.
`default_nettype none

module bffa_ffz #(
  parameter int WIDTH = 32,
  parameter int IDX_W = 5
) (
  input  wire logic [WIDTH-1:0] word,
  output logic                  full,
  output logic      [WIDTH-1:0] onehot,
  output logic      [IDX_W-1:0] idx
);

  logic [WIDTH-1:0] inv;

  assign inv    = ~word;
  assign onehot = inv & (~inv + WIDTH'(1));
  assign full   = (inv == '0);

  always_comb begin
    idx = '0;
    for (int j = 0; j < IDX_W; j++) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (((i >> j) & 1) == 1) begin
          idx[j] = idx[j] | onehot[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/bffa_div.sv
// Split of a bitmap offset into word index and bit index for a power-of-two word width.
`default_nettype none

module bffa_div #(
  parameter int OFS_W  = 10,
  parameter int AW     = 5,
  parameter int BIDX_W = 5
) (
  input  wire logic [OFS_W-1:0]  offset,
  output logic      [AW-1:0]     word_idx,
  output logic      [BIDX_W-1:0] bit_idx
);

  assign word_idx = AW'(offset >> BIDX_W);
  assign bit_idx  = offset[BIDX_W-1:0];

endmodule

`default_nettype wire

FILE: sv/bitmap_first_free_allocator.sv
// Top level of the first-fit bitmap allocator: sequencer, counters and result register.
// After reset the block runs a clearing pass of one bitmap word per cycle and holds in_stall
// high meanwhile. One item is worked on at a time; WORD_BITS must be a power of two. An
// allocate reads the bitmap words from the lowest through the single find-first-zero unit:
// each word that is passed over is loaded and scanned, and each granted entry is set and
// reported from the scan state. A free in range reads the word, clears the bit (or flags a
// bad free if it is already clear) and then reports. A rejected or zero-count command goes
// straight to the report state, which loads its single result. A stalled result register
// holds the sequencer until it is taken.
`default_nettype none

module bitmap_first_free_allocator #(
  parameter int MAP_BITS  = 1024,
  parameter int MAX_RUN   = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] base_number,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [4:0]  alloc_count,
  input  wire logic [31:0] free_number,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      granted_number,
  output logic             last,
  output logic [10:0]      free_left
);

  localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIDX_W    = $clog2(WORD_BITS);
  localparam int REL_W     = $clog2(MAP_BITS);
  localparam int CNT_W     = $clog2(MAP_BITS + 1);
  localparam int RUN_W     = $clog2(MAX_RUN + 1);
  localparam int TAIL      = MAP_BITS - (NUM_WORDS - 1) * WORD_BITS;
  localparam logic [AW-1:0]        LAST_WORD = AW'(NUM_WORDS - 1);
  localparam logic [WORD_BITS-1:0] TAIL_MASK = {WORD_BITS{1'b1}} << TAIL;

  bffa_pkg::state_t state, state_next;

  logic [AW-1:0]                       clr_addr, clr_addr_next;
  logic [AW-1:0]                       addr, addr_next;
  logic [31:0]                         num_base, num_base_next;
  logic [WORD_BITS-1:0]                word, word_next;
  logic [RUN_W-1:0]                    want, want_next;
  logic [RUN_W-1:0]                    granted, granted_next;
  logic [CNT_W-1:0]                    free_count, free_count_next;
  logic [bffa_pkg::STATUS_W-1:0]       rep_status, rep_status_next;
  logic [BIDX_W-1:0]                   free_bit, free_bit_next;
  logic [31:0]                         base;

  logic                  accept;
  logic                  out_free;
  logic [RUN_W-1:0]      want_in;
  logic [31:0]           rel_full;
  logic                  rel_ok;
  logic                  grant_last;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [WORD_BITS-1:0]  rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [WORD_BITS-1:0]  wr_data;

  logic                  full;
  logic [WORD_BITS-1:0]  onehot;
  logic [BIDX_W-1:0]     idx;

  logic [AW-1:0]         split_word;
  logic [BIDX_W-1:0]     split_bit;

  logic                                emit;
  logic [bffa_pkg::STATUS_W-1:0]       emit_status;
  logic [31:0]                         emit_num;
  logic                                emit_last;

  bffa_ram #(
    .DEPTH(NUM_WORDS),
    .WIDTH(WORD_BITS),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  bffa_ffz #(
    .WIDTH(WORD_BITS),
    .IDX_W(BIDX_W)
  ) u_ffz (
    .word  (word),
    .full  (full),
    .onehot(onehot),
    .idx   (idx)
  );

  bffa_div #(
    .OFS_W (REL_W),
    .AW    (AW),
    .BIDX_W(BIDX_W)
  ) u_div (
    .offset  (REL_W'(rel_full)),
    .word_idx(split_word),
    .bit_idx (split_bit)
  );

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state != bffa_pkg::ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign want_in    = (32'(alloc_count) > 32'(MAX_RUN)) ? RUN_W'(MAX_RUN) : RUN_W'(alloc_count);
  assign rel_full   = free_number - base;
  assign rel_ok     = (rel_full < 32'(MAP_BITS));
  assign grant_last = (RUN_W'(granted + RUN_W'(1)) == want);

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    addr_next       = addr;
    num_base_next   = num_base;
    word_next       = word;
    want_next       = want;
    granted_next    = granted;
    free_count_next = free_count;
    rep_status_next = rep_status;
    free_bit_next   = free_bit;
    rd_en           = 1'b0;
    rd_addr         = addr;
    wr_en           = 1'b0;
    wr_addr         = addr;
    wr_data         = word;
    emit            = 1'b0;
    emit_status     = bffa_pkg::STATUS_OK;
    emit_num        = '0;
    emit_last       = 1'b1;

    case (state)
      bffa_pkg::ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        wr_data       = (clr_addr == LAST_WORD) ? TAIL_MASK : '0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == LAST_WORD) begin
          state_next = bffa_pkg::ST_IDLE;
        end
      end
      bffa_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd == bffa_pkg::CMD_ALLOC) begin
            if (want_in == '0) begin
              rep_status_next = bffa_pkg::STATUS_OK;
              state_next      = bffa_pkg::ST_REPORT;
            end else if (32'(free_count) < 32'(want_in)) begin
              rep_status_next = bffa_pkg::STATUS_NO_SPACE;
              state_next      = bffa_pkg::ST_REPORT;
            end else begin
              want_next     = want_in;
              granted_next  = '0;
              addr_next     = '0;
              num_base_next = base;
              rd_en         = 1'b1;
              rd_addr       = '0;
              state_next    = bffa_pkg::ST_LOAD;
            end
          end else begin
            if (!rel_ok) begin
              rep_status_next = bffa_pkg::STATUS_BAD_FREE;
              state_next      = bffa_pkg::ST_REPORT;
            end else begin
              addr_next     = split_word;
              free_bit_next = split_bit;
              rd_en         = 1'b1;
              rd_addr       = split_word;
              state_next    = bffa_pkg::ST_FLOAD;
            end
          end
        end
      end
      bffa_pkg::ST_REPORT: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = rep_status;
          state_next  = bffa_pkg::ST_IDLE;
        end
      end
      bffa_pkg::ST_LOAD: begin
        word_next  = rd_data;
        state_next = bffa_pkg::ST_SCAN;
      end
      bffa_pkg::ST_SCAN: begin
        if (full) begin
          addr_next     = addr + AW'(1);
          num_base_next = num_base + 32'(WORD_BITS);
          rd_en         = 1'b1;
          rd_addr       = addr + AW'(1);
          state_next    = bffa_pkg::ST_LOAD;
        end else if (out_free) begin
          word_next       = word | onehot;
          wr_en           = 1'b1;
          wr_data         = word | onehot;
          free_count_next = free_count - CNT_W'(1);
          granted_next    = granted + RUN_W'(1);
          emit            = 1'b1;
          emit_num        = num_base + 32'(idx);
          emit_last       = grant_last;
          if (grant_last) begin
            state_next = bffa_pkg::ST_IDLE;
          end
        end
      end
      bffa_pkg::ST_FLOAD: begin
        if (!rd_data[free_bit]) begin
          rep_status_next = bffa_pkg::STATUS_BAD_FREE;
        end else begin
          wr_en           = 1'b1;
          wr_data         = rd_data & ~(WORD_BITS'(1) << free_bit);
          free_count_next = free_count + CNT_W'(1);
          rep_status_next = bffa_pkg::STATUS_OK;
        end
        state_next = bffa_pkg::ST_REPORT;
      end
      default: begin
        state_next = bffa_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bffa_pkg::ST_CLEAR;
      clr_addr   <= '0;
      free_count <= CNT_W'(MAP_BITS);
      base       <= bffa_pkg::BASE_RESET;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      free_count <= free_count_next;
      if (cfg_valid && cfg_ready) begin
        base <= base_number;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr       <= addr_next;
    num_base   <= num_base_next;
    word       <= word_next;
    want       <= want_next;
    granted    <= granted_next;
    rep_status <= rep_status_next;
    free_bit   <= free_bit_next;
    if (emit) begin
      status         <= emit_status;
      granted_number <= emit_num;
      last           <= emit_last;
      free_left      <= bffa_pkg::FREE_LEFT_W'(free_count_next);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= CNT_W'(MAP_BITS))
    else $error("free counter above map size");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != bffa_pkg::STATUS_OK) |-> last)
    else $error("error result not marked last");

  a_scan_within_request: assert property (@(posedge clk) disable iff (rst)
    (state == bffa_pkg::ST_SCAN) |-> (granted < want))
    else $error("scan running past the requested count");

  a_load_entry: assert property (@(posedge clk) disable iff (rst)
    (state == bffa_pkg::ST_LOAD) |->
      ($past(state) == bffa_pkg::ST_IDLE) || ($past(state) == bffa_pkg::ST_SCAN))
    else $error("word load entered from a wrong state");

  a_clear_done_full: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == bffa_pkg::ST_CLEAR) && (state == bffa_pkg::ST_IDLE) |->
      (free_count == CNT_W'(MAP_BITS)))
    else $error("free counter wrong after clearing pass");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_bitmap_first_free_allocator.sv
// Self-checking bench for the first-fit bitmap allocator: random and directed commands.
`default_nettype none

module tb_bitmap_first_free_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_BITS  = 1024;
  localparam int MAX_RUN   = 16;
  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = MAP_BITS / WORD_BITS;
  localparam int SETTLE_CYCLES = 120;

  typedef struct packed {
    logic [bffa_pkg::STATUS_W-1:0]    status;
    logic [bffa_pkg::ADDR_NUM_W-1:0]  granted;
    logic                             last;
    logic [bffa_pkg::FREE_LEFT_W-1:0] free_left;
  } grant_result_t;

  class allocation_tracker;
    logic [WORD_BITS-1:0]            usage [NUM_WORDS];
    int unsigned                     free_cnt;
    logic [bffa_pkg::ADDR_NUM_W-1:0] base;
    grant_result_t                   grants_due [$];
    int                              failures;
    int                              results_seen;

    function new();
      foreach (usage[i]) usage[i] = '0;
      free_cnt = MAP_BITS;
      base = bffa_pkg::BASE_RESET;
      failures = 0;
      results_seen = 0;
    endfunction

    function void push_result(logic [bffa_pkg::STATUS_W-1:0] st,
                              logic [bffa_pkg::ADDR_NUM_W-1:0] num, logic lst);
      grant_result_t r;
      r.status = st;
      r.granted = num;
      r.last = lst;
      r.free_left = bffa_pkg::FREE_LEFT_W'(free_cnt);
      grants_due.push_back(r);
    endfunction

    function void note_command(logic c, logic [bffa_pkg::COUNT_IN_W-1:0] cnt,
                               logic [bffa_pkg::ADDR_NUM_W-1:0] fnum);
      int unsigned want;
      int unsigned granted;
      logic [bffa_pkg::ADDR_NUM_W-1:0] rel;
      if (c == bffa_pkg::CMD_ALLOC) begin
        want = cnt;
        if (want > MAX_RUN) want = MAX_RUN;
        if (want == 0) begin
          push_result(bffa_pkg::STATUS_OK, '0, 1'b1);
        end else if (free_cnt < want) begin
          push_result(bffa_pkg::STATUS_NO_SPACE, '0, 1'b1);
        end else begin
          granted = 0;
          for (int idx = 0; idx < MAP_BITS && granted < want; idx++) begin
            if (!usage[idx / WORD_BITS][idx % WORD_BITS]) begin
              usage[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
              free_cnt--;
              granted++;
              push_result(bffa_pkg::STATUS_OK, base + bffa_pkg::ADDR_NUM_W'(idx),
                          granted == want);
            end
          end
        end
      end else begin
        rel = fnum - base;
        if (rel >= MAP_BITS) begin
          push_result(bffa_pkg::STATUS_BAD_FREE, '0, 1'b1);
        end else if (!usage[rel / WORD_BITS][rel % WORD_BITS]) begin
          push_result(bffa_pkg::STATUS_BAD_FREE, '0, 1'b1);
        end else begin
          usage[rel / WORD_BITS][rel % WORD_BITS] = 1'b0;
          free_cnt++;
          push_result(bffa_pkg::STATUS_OK, '0, 1'b1);
        end
      end
    endfunction

    function void check_grant(logic [bffa_pkg::STATUS_W-1:0] st,
                              logic [bffa_pkg::ADDR_NUM_W-1:0] num, logic lst,
                              logic [bffa_pkg::FREE_LEFT_W-1:0] fl);
      grant_result_t e;
      results_seen++;
      if (grants_due.size() == 0) begin
        $error("unexpected result: status %0d granted_number %0h last %0d free_left %0d",
               st, num, lst, fl);
        failures++;
        return;
      end
      e = grants_due.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        failures++;
      end
      if (num !== e.granted) begin
        $error("granted_number: expected %0h, actual %0h", e.granted, num);
        failures++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, lst);
        failures++;
      end
      if (fl !== e.free_left) begin
        $error("free_left: expected %0d, actual %0d", e.free_left, fl);
        failures++;
      end
    endfunction

    function int pending();
      return grants_due.size();
    endfunction

    // Random bit index that is in use (want_used) or clear; -1 if none in use.
    function int pick_index(bit want_used);
      int hits [$];
      for (int i = 0; i < MAP_BITS; i++)
        if (usage[i / WORD_BITS][i % WORD_BITS] == want_used) hits.push_back(i);
      if (hits.size() == 0) return want_used ? -1 : $urandom_range(MAP_BITS - 1);
      return hits[$urandom_range(hits.size() - 1)];
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [bffa_pkg::ADDR_NUM_W-1:0]  base_number;
  logic                             in_valid;
  logic                             in_stall;
  logic                             cmd;
  logic [bffa_pkg::COUNT_IN_W-1:0]  alloc_count;
  logic [bffa_pkg::ADDR_NUM_W-1:0]  free_number;
  logic                             out_valid;
  logic                             out_stall;
  logic [bffa_pkg::STATUS_W-1:0]    status;
  logic [bffa_pkg::ADDR_NUM_W-1:0]  granted_number;
  logic                             last;
  logic [bffa_pkg::FREE_LEFT_W-1:0] free_left;

  bit calm;
  bit hold_request;

  allocation_tracker tracker = new();

  bitmap_first_free_allocator #(
    .MAP_BITS  (MAP_BITS),
    .MAX_RUN   (MAX_RUN),
    .WORD_BITS (WORD_BITS)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .base_number    (base_number),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .alloc_count    (alloc_count),
    .free_number    (free_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .granted_number (granted_number),
    .last           (last),
    .free_left      (free_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_grant(status, granted_number, last, free_left);
  end

  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 11);
      end
    end
  end

  // Entered and left at a falling edge; valid stays high after the item.
  task automatic send_item(logic c, logic [bffa_pkg::COUNT_IN_W-1:0] cnt,
                           logic [bffa_pkg::ADDR_NUM_W-1:0] fnum);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    alloc_count <= cnt;
    free_number <= fnum;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_command(c, cnt, fnum);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_base(logic [bffa_pkg::ADDR_NUM_W-1:0] value);
    cfg_valid   <= 1'b1;
    base_number <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.base = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(int alloc_pct, bit fill);
    logic                            c;
    logic [bffa_pkg::COUNT_IN_W-1:0] cnt;
    logic [bffa_pkg::ADDR_NUM_W-1:0] fnum;
    int                              pick;
    int                              idx;
    cnt  = fill ? bffa_pkg::COUNT_IN_W'(MAX_RUN)
                : bffa_pkg::COUNT_IN_W'($urandom_range(1, MAX_RUN));
    fnum = $urandom;
    pick = $urandom_range(99);
    if ($urandom_range(99) < alloc_pct) begin
      c = bffa_pkg::CMD_ALLOC;
      if (pick < 4) cnt = '0;
      else if (pick < 10) cnt = bffa_pkg::COUNT_IN_W'($urandom_range(MAX_RUN + 1, 31));
    end else begin
      c = bffa_pkg::CMD_FREE;
      idx = tracker.pick_index(1'b1);
      if (pick < 78 && idx >= 0) fnum = tracker.base + bffa_pkg::ADDR_NUM_W'(idx);
      else if (pick < 90)
        fnum = tracker.base + bffa_pkg::ADDR_NUM_W'(tracker.pick_index(1'b0));
      else if (pick < 95) fnum = tracker.base - 1 - $urandom_range(7);
      else fnum = tracker.base + MAP_BITS + $urandom_range(7);
    end
    send_item(c, cnt, fnum);
  endtask

  task automatic run_phase(logic [bffa_pkg::ADDR_NUM_W-1:0] new_base, int n, int alloc_pct,
                           bit fill, bit quiet, bit hold, bit mid_pause);
    drain();
    write_base(new_base);
    calm = quiet;
    hold_request = hold;
    for (int i = 0; i < n; i++) begin
      if (mid_pause && i == n / 2) begin
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge clk);
      end
      send_random(alloc_pct, fill);
    end
    calm = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    base_number = '0;
    in_valid    = 1'b0;
    cmd         = bffa_pkg::CMD_ALLOC;
    alloc_count = '0;
    free_number = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(bffa_pkg::CMD_ALLOC, 5'd1, 32'hFFFF_FFFF);
    send_item(bffa_pkg::CMD_ALLOC, 5'd16, $urandom);
    send_item(bffa_pkg::CMD_ALLOC, 5'd0, $urandom);
    send_item(bffa_pkg::CMD_ALLOC, 5'd31, $urandom);
    send_item(bffa_pkg::CMD_ALLOC, 5'd17, 32'h0);
    send_item(bffa_pkg::CMD_FREE, 5'd1, tracker.base);
    send_item(bffa_pkg::CMD_FREE, 5'd1, tracker.base);
    send_item(bffa_pkg::CMD_FREE, 5'd31, tracker.base - 1);
    send_item(bffa_pkg::CMD_FREE, 5'd0, tracker.base + MAP_BITS);
    send_item(bffa_pkg::CMD_FREE, 5'd16, tracker.base + MAP_BITS - 1);
    send_item(bffa_pkg::CMD_ALLOC, 5'd1, $urandom);
    send_item(bffa_pkg::CMD_FREE, 5'd2, tracker.base + 5);
    send_item(bffa_pkg::CMD_FREE, 5'd2, tracker.base + 20);
    send_item(bffa_pkg::CMD_ALLOC, 5'd3, $urandom);
    send_item(bffa_pkg::CMD_FREE, 5'd1, 32'hFFFF_FFFF);
    send_item(bffa_pkg::CMD_FREE, 5'd1, 32'h0);
    drain();
    write_base(32'hFFFF_FFFF);
    send_item(bffa_pkg::CMD_ALLOC, 5'd2, $urandom);
    send_item(bffa_pkg::CMD_FREE, 5'd1, 32'hFFFF_FFFF);
    send_item(bffa_pkg::CMD_FREE, 5'd1, 32'h0);
    drain();
    write_base(32'h0);
    send_item(bffa_pkg::CMD_FREE, 5'd1, 32'h0);
    send_item(bffa_pkg::CMD_ALLOC, 5'd16, 32'hFFFF_FFFF);

    run_phase($urandom, 70, 55, 1'b0, 1'b0, 1'b1, 1'b0);
    run_phase(32'hFFFF_FFF0, 80, 92, 1'b1, 1'b0, 1'b0, 1'b0);
    run_phase(32'h0, 60, 25, 1'b0, 1'b1, 1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF, 50, 50, 1'b0, 1'b0, 1'b0, 1'b1);
    drain();

    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: bitmap_first_free_allocator.f
sv/bffa_pkg.sv
sv/bffa_ram.sv
sv/bffa_ffz.sv
sv/bffa_div.sv
sv/bitmap_first_free_allocator.sv
bench/tb_bitmap_first_free_allocator.sv
